// File: hdl/tdpf_pkg.sv
package tdpf_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int MAX_RESULTS    = 9;
  localparam int CNT_BITS       = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_TEST,
    ST_DSTART,
    ST_DWAIT,
    ST_CHECK,
    ST_FIN,
    ST_LAST
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic divide_out;
    logic next_div;
    logic push_nf;
    logic push_pend;
    logic push_last;
    logic pend_rem;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic r_lt2;
    logic r_gt1;
    logic sq_le_r;
    logic div_busy;
    logic rem_zero;
    logic hit;
    logic count_max;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

// File: hdl/tdpf_div.sv
module tdpf_div #(
  parameter int VALUE_BITS = tdpf_pkg::VALUE_BITS_DEF,
  parameter int DBITS      = (VALUE_BITS + 1) / 2 + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [DBITS-1:0]      divisor,
  output logic                  busy,
  output logic [VALUE_BITS-1:0] quot,
  output logic [DBITS-1:0]      rem
);

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [CW-1:0]         cnt;
  logic [VALUE_BITS-1:0] q;
  logic [DBITS-1:0]      p;
  logic [DBITS:0]        p_shift;
  logic                  ge;
  logic [DBITS-1:0]      p_next;

  // Restoring division, one quotient bit per cycle, dividend bits MSB first.
  assign p_shift = {p, q[VALUE_BITS-1]};
  assign ge      = p_shift >= {1'b0, divisor};
  assign p_next  = ge ? DBITS'(p_shift - {1'b0, divisor}) : p_shift[DBITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(VALUE_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      p <= '0;
    end else if (busy) begin
      q <= {q[VALUE_BITS-2:0], ge};
      p <= p_next;
    end
  end

  assign quot = q;
  assign rem  = p;

endmodule

// File: hdl/tdpf_datapath.sv
module tdpf_datapath #(
  parameter int VALUE_BITS = tdpf_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  tdpf_pkg::cmd_t          cmd,
  output tdpf_pkg::status_t       status,
  input  logic [VALUE_BITS-1:0]   value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [VALUE_BITS-1:0]   factor,
  output logic                    no_factor,
  output logic                    last
);

  localparam int DBITS   = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_BITS = 2 * DBITS;

  logic [VALUE_BITS-1:0]        r;
  logic [DBITS-1:0]             d;
  logic [SQ_BITS-1:0]           sq;
  logic                         hit;
  logic [tdpf_pkg::CNT_BITS-1:0] count;
  logic [VALUE_BITS-1:0]        pend;
  logic                         pend_valid;
  logic                         div_busy;
  logic [VALUE_BITS-1:0]        quot;
  logic [DBITS-1:0]             rem;
  logic                         first_hit;

  tdpf_div #(
    .VALUE_BITS (VALUE_BITS),
    .DBITS      (DBITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (r),
    .divisor  (d),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  assign first_hit = cmd.divide_out && !hit;

  // The square of the divisor is tracked by adding 2d + 1 on each step.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r  <= value;
      d  <= DBITS'(2);
      sq <= SQ_BITS'(4);
    end else begin
      if (cmd.divide_out) begin
        r <= quot;
      end
      if (cmd.next_div) begin
        d  <= d + 1'b1;
        sq <= sq + SQ_BITS'({d, 1'b1});
      end
    end
    if (first_hit) begin
      pend <= VALUE_BITS'(d);
    end else if (cmd.pend_rem) begin
      pend <= r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit        <= 1'b0;
      count      <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.load) begin
      hit        <= 1'b0;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (first_hit) begin
        hit <= 1'b1;
      end else if (cmd.next_div) begin
        hit <= 1'b0;
      end
      if (first_hit || cmd.pend_rem) begin
        count      <= count + 1'b1;
        pend_valid <= 1'b1;
      end
    end
  end

  // Output register; the controller pushes only when it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_nf || cmd.push_pend) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_nf) begin
      factor    <= '0;
      no_factor <= 1'b1;
      last      <= 1'b1;
    end else if (cmd.push_pend) begin
      factor    <= pend;
      no_factor <= 1'b0;
      last      <= cmd.push_last;
    end
  end

  always_comb begin
    status.r_lt2      = r < VALUE_BITS'(2);
    status.r_gt1      = r > VALUE_BITS'(1);
    status.sq_le_r    = sq <= SQ_BITS'(r);
    status.div_busy   = div_busy;
    status.rem_zero   = rem == '0;
    status.hit        = hit;
    status.count_max  = count == tdpf_pkg::CNT_BITS'(tdpf_pkg::MAX_RESULTS);
    status.pend_valid = pend_valid;
    status.out_free   = !out_valid || out_ready;
  end

endmodule

// File: hdl/tdpf_ctrl.sv
module tdpf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tdpf_pkg::status_t status,
  output tdpf_pkg::cmd_t    cmd
);

  tdpf_pkg::state_t state;
  tdpf_pkg::state_t state_next;
  logic             pend_ok;

  // A pending factor can move to the output only when the register is free.
  assign pend_ok = !status.pend_valid || status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdpf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tdpf_pkg::ST_IDLE: begin
        if (in_valid) state_next = tdpf_pkg::ST_START;
      end
      tdpf_pkg::ST_START: begin
        if (!status.r_lt2) state_next = tdpf_pkg::ST_TEST;
        else if (status.out_free) state_next = tdpf_pkg::ST_IDLE;
      end
      tdpf_pkg::ST_TEST: begin
        state_next = status.sq_le_r ? tdpf_pkg::ST_DSTART : tdpf_pkg::ST_FIN;
      end
      tdpf_pkg::ST_DSTART: begin
        state_next = tdpf_pkg::ST_DWAIT;
      end
      tdpf_pkg::ST_DWAIT: begin
        if (!status.div_busy) state_next = tdpf_pkg::ST_CHECK;
      end
      tdpf_pkg::ST_CHECK: begin
        if (!status.rem_zero) state_next = tdpf_pkg::ST_TEST;
        else if (status.hit) state_next = tdpf_pkg::ST_DSTART;
        else if (status.count_max) state_next = tdpf_pkg::ST_FIN;
        else if (pend_ok) state_next = tdpf_pkg::ST_DSTART;
      end
      tdpf_pkg::ST_FIN: begin
        if (!status.r_gt1 || status.count_max || pend_ok) state_next = tdpf_pkg::ST_LAST;
      end
      tdpf_pkg::ST_LAST: begin
        if (status.out_free) state_next = tdpf_pkg::ST_IDLE;
      end
      default: begin
        state_next = tdpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      tdpf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      tdpf_pkg::ST_START: begin
        cmd.push_nf = status.r_lt2 && status.out_free;
      end
      tdpf_pkg::ST_DSTART: begin
        cmd.div_start = 1'b1;
      end
      tdpf_pkg::ST_CHECK: begin
        if (!status.rem_zero) begin
          cmd.next_div = 1'b1;
        end else if (status.hit) begin
          cmd.divide_out = 1'b1;
        end else if (!status.count_max && pend_ok) begin
          // A new factor: the previous one is known not to be the last.
          cmd.divide_out = 1'b1;
          cmd.push_pend  = status.pend_valid;
        end
      end
      tdpf_pkg::ST_FIN: begin
        if (status.r_gt1 && !status.count_max && pend_ok) begin
          cmd.push_pend = status.pend_valid;
          cmd.pend_rem  = 1'b1;
        end
      end
      tdpf_pkg::ST_LAST: begin
        cmd.push_pend = status.out_free;
        cmd.push_last = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: hdl/trial_division_prime_factors.sv
// Each trial divisor, and each extra division that removes a repeated factor, runs one
// pass of the bit-serial divider, which produces one quotient bit per cycle.
// Throughput: one input at a time; the next input is taken once the last result is loaded
// into the output register. Synchronous active-high reset clears the controller and the
// valid flags; no clearing pass is needed.
module trial_division_prime_factors #(
  parameter int VALUE_BITS = tdpf_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] factor,
  output logic                  no_factor,
  output logic                  last
);

  tdpf_pkg::cmd_t    cmd;
  tdpf_pkg::status_t status;

  tdpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tdpf_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .factor    (factor),
    .no_factor (no_factor),
    .last      (last)
  );

endmodule

// File: bench/tb_trial_division_prime_factors.sv
`timescale 1ns / 1ps

module tb_trial_division_prime_factors;

  localparam int VALUE_BITS  = tdpf_pkg::VALUE_BITS_DEF;
  localparam int STALL_LIMIT = 200000;
  localparam int TAIL_CYCLES = 4 * (VALUE_BITS + 3);
  localparam int RANDOM_JOBS = 80;

  typedef struct {
    logic [VALUE_BITS-1:0] prime;
    logic                  no_factor;
    logic                  is_last;
  } factor_t;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    bit                    drain_first;
  } job_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VALUE_BITS-1:0] factor;
  logic                  no_factor;
  logic                  last;

  job_t    jobs_todo[$];
  factor_t factors_due[$];

  int   predicted_total = 0;
  int   checked_total = 0;
  int   sent_jobs = 0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   errors = 0;
  int   stall_cycles = 0;
  logic idle_ok = 1'b1;

  trial_division_prime_factors #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .factor   (factor),
    .no_factor(no_factor),
    .last     (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Works out the distinct prime factors of one accepted value and queues them.
  task automatic factorize(input logic [VALUE_BITS-1:0] v);
    longint unsigned rest;
    longint unsigned d;
    factor_t         found[$];
    factor_t         rec;
    rest = 64'(v);
    if (rest < 2) begin
      rec.prime = '0;
      rec.no_factor = 1'b1;
      rec.is_last = 1'b1;
      found.insert(found.size(), rec);
    end else begin
      rec.no_factor = 1'b0;
      rec.is_last = 1'b0;
      d = 2;
      while (d <= rest / d) begin
        if (rest % d == 0) begin
          if (found.size() >= tdpf_pkg::MAX_RESULTS) break;
          rec.prime = d[VALUE_BITS-1:0];
          found.insert(found.size(), rec);
          while (rest % d == 0) rest = rest / d;
        end
        d++;
      end
      if (rest > 1 && found.size() < tdpf_pkg::MAX_RESULTS) begin
        rec.prime = rest[VALUE_BITS-1:0];
        found.insert(found.size(), rec);
      end
      found[found.size() - 1].is_last = 1'b1;
    end
    foreach (found[i]) factors_due.insert(factors_due.size(), found[i]);
    predicted_total += found.size();
  endtask

  task automatic queue_job(input longint unsigned v, input bit drain_first);
    job_t j;
    j.value = v[VALUE_BITS-1:0];
    j.drain_first = drain_first;
    jobs_todo.insert(jobs_todo.size(), j);
  endtask

  // Multiplies by small random integers, so every prime factor added stays below 100
  // and the trial search stays short even for large products.
  function automatic longint unsigned smooth_mul(input longint unsigned base, input int times);
    longint unsigned acc;
    longint unsigned q;
    acc = base;
    for (int i = 0; i < times; i++) begin
      q = $urandom_range(2, 97);
      if (acc * q < (64'd1 << VALUE_BITS)) acc = acc * q;
    end
    return acc;
  endfunction

  // Sender side.
  always @(posedge clk) begin
    job_t j;
    logic take_next;
    take_next = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (!in_valid || in_ready) begin
        if (in_valid) begin
          factorize(value);
          sent_jobs++;
          if (idle_ok && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 3);
        end
        if (in_gap > 0) begin
          in_gap--;
        end else if (jobs_todo.size() != 0) begin
          // A drain job is held back until every factor already owed has come out.
          if (!jobs_todo[0].drain_first || checked_total >= predicted_total) take_next = 1'b1;
        end
        if (take_next) begin
          j = jobs_todo.pop_front();
          value <= j.value;
        end
        in_valid <= take_next;
      end
      idle_ok <= (jobs_todo.size() >= 15) && ((sent_jobs % 30) < 20);
    end
  end

  // Receiver side: stalls and checks.
  always @(posedge clk) begin
    factor_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        checked_total <= checked_total + 1;
        if (factors_due.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction factor=%0d no_factor=%0b last=%0b",
                                    factor, no_factor, last));
        end else begin
          want = factors_due.pop_front();
          if (factor !== want.prime)
            report_mismatch($sformatf("factor %0d, expected %0d", factor, want.prime));
          if (no_factor !== want.no_factor)
            report_mismatch($sformatf("no_factor %0b, expected %0b", no_factor, want.no_factor));
          if (last !== want.is_last)
            report_mismatch($sformatf("last %0b, expected %0b (factor %0d)",
                                      last, want.is_last, want.prime));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Ends the run if neither side moves a transaction for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int mode;
    rst = 1'b1;

    // Directed: inputs below two, small primes, prime powers, many distinct factors,
    // alternating bit patterns and the widest values that keep the search short.
    queue_job(0, 1'b0);
    queue_job(1, 1'b0);
    queue_job(2, 1'b0);
    queue_job(3, 1'b0);
    queue_job(4, 1'b0);
    queue_job(6, 1'b0);
    queue_job(30, 1'b0);
    queue_job(64'h7FFF_FFFE, 1'b0);
    queue_job(64'h4000_0000, 1'b0);
    queue_job(223092870, 1'b0);
    queue_job(1162261467, 1'b1);
    queue_job(64'h5555_5555, 1'b0);
    queue_job(64'h2AAA_AAAA, 1'b0);
    queue_job(65521, 1'b0);
    queue_job(63001, 1'b0);
    queue_job(1000003, 1'b0);
    queue_job(1, 1'b1);
    queue_job(0, 1'b0);
    queue_job(97 * 89, 1'b0);
    queue_job(64'h0001_0000, 1'b0);

    for (int i = 0; i < RANDOM_JOBS; i++) begin
      mode = $urandom_range(0, 99);
      if (mode < 5)
        queue_job($urandom_range(0, 1), 1'b0);
      else if (mode < 35)
        queue_job($urandom_range(2, 5000), i == 40);
      else if (mode < 70)
        queue_job(smooth_mul(1, $urandom_range(1, 14)), 1'b0);
      else if (mode < 88)
        queue_job(longint'($urandom_range(1, 2047)) << $urandom_range(0, 20), 1'b0);
      else
        queue_job(smooth_mul($urandom_range(2, 1 << 18), $urandom_range(0, 4)), 1'b0);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (jobs_todo.size() != 0 || in_valid || checked_total < predicted_total)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
